// ===== rtl/core/shm_pkg.sv =====
package shm_pkg;

  // Sequence length default and config port index width
  localparam int SEQ_LEN_DEFAULT = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int SEQ_BYTES       = 4;

  // Register reset values
  localparam logic [15:0] SERVICE_LIMIT_RST   = 16'd400;
  localparam logic [15:0] WARNING_LIMIT_RST   = 16'd390;
  localparam logic [15:0] QUARTER_SECONDS_RST = 16'd900;
  localparam logic [7:0]  UNLOCK_TIMEOUT_RST  = 8'd5;
  localparam logic [15:0] BLINK_HALF_RST      = 16'd500;
  localparam logic [31:0] UNLOCK_SEQ_RST      = 32'h0401_0401;

  localparam logic [2:0]  QUARTERS_PER_HOUR   = 3'd4;
  localparam logic [15:0] HOURS_MAX           = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVICE_LIMIT   = 3'd0,
    REG_WARNING_LIMIT   = 3'd1,
    REG_QUARTER_SECONDS = 3'd2,
    REG_UNLOCK_TIMEOUT  = 3'd3,
    REG_BLINK_HALF      = 3'd4,
    REG_UNLOCK_SEQUENCE = 3'd5
  } shm_reg_e;

  typedef enum logic {
    ACT_CHECK = 1'b0,
    ACT_KEY   = 1'b1
  } shm_action_e;

  typedef struct packed {
    logic [15:0] service_limit;
    logic [15:0] warning_limit;
    logic [15:0] quarter_seconds;
    logic [7:0]  unlock_timeout_seconds;
    logic [15:0] blink_half_period_ms;
    logic [31:0] unlock_sequence;
  } shm_cfg_t;

  typedef struct packed {
    logic [15:0] hours_total;
    logic [15:0] hours_at_service;
    logic [2:0]  quarters;
    logic [31:0] quarter_stamp;
    logic        quarter_stamp_valid;
    logic [31:0] unlock_stamp;
    logic        unlock_active;
    logic [31:0] blink_stamp;
    logic        led_state;
  } shm_core_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  key_code;
    logic [31:0] now_seconds;
    logic [31:0] now_millis;
  } shm_item_t;

  typedef struct packed {
    logic        service_required;
    logic        service_warning;
    logic        reset_done;
    logic        led_on;
    logic [15:0] operation_hours;
    logic [2:0]  quarter_count;
  } shm_result_t;

  // Expected key code at a sequence position; positions past the register read as zero
  function automatic logic [7:0] expected_key(input logic [31:0] seq, input int unsigned pos);
    logic [31:0] sh;
    sh = 32'd0;
    if (pos >= SEQ_BYTES) begin
      return 8'd0;
    end
    sh = seq >> (8 * pos);
    return sh[7:0];
  endfunction

endpackage

// ===== rtl/core/shm_if.sv =====
interface shm_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  key_code;
  logic [31:0] now_seconds;
  logic [31:0] now_millis;

  modport source (output valid, action, key_code, now_seconds, now_millis, input ready);
  modport sink   (input valid, action, key_code, now_seconds, now_millis, output ready);
endinterface

interface shm_result_if;
  logic        valid;
  logic        ready;
  logic        service_required;
  logic        service_warning;
  logic        reset_done;
  logic        led_on;
  logic [15:0] operation_hours;
  logic [2:0]  quarter_count;

  modport source (output valid, service_required, service_warning, reset_done, led_on,
                  operation_hours, quarter_count, input ready);
  modport sink   (input valid, service_required, service_warning, reset_done, led_on,
                  operation_hours, quarter_count, output ready);
endinterface

interface shm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/shm_step.sv =====
module shm_step
  import shm_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEFAULT,
  localparam int CNT_W = $clog2(SEQ_LEN + 1)
) (
  input  shm_cfg_t                    cfg,
  input  shm_core_t                   st,
  input  logic [SEQ_LEN-1:0][7:0]     keys,
  input  logic [CNT_W-1:0]            count,
  input  shm_item_t                   item,
  output shm_core_t                   st_next,
  output logic [SEQ_LEN-1:0][7:0]     keys_next,
  output logic [CNT_W-1:0]            count_next,
  output shm_result_t                 res
);

  logic [15:0]             since;
  logic                    req;
  logic                    warn;
  logic [31:0]             q_elapsed;
  logic                    q_due;
  logic [2:0]              q_inc;
  logic [31:0]             u_elapsed;
  logic                    u_expired;
  logic [31:0]             b_elapsed;
  logic                    b_due;
  logic [CNT_W-1:0]        slot;
  logic [CNT_W-1:0]        slot_plus;
  logic                    seq_full;
  logic                    seq_match;
  logic [SEQ_LEN-1:0][7:0] keys_wr;

  // Compare hours since service and elapsed times
  always_comb begin
    since     = st.hours_total - st.hours_at_service;
    req       = since >= cfg.service_limit;
    warn      = since >= cfg.warning_limit;
    q_elapsed = item.now_seconds - st.quarter_stamp;
    q_due     = !st.quarter_stamp_valid || (q_elapsed > {16'd0, cfg.quarter_seconds});
    q_inc     = st.quarters + 3'd1;
    u_elapsed = item.now_seconds - st.unlock_stamp;
    u_expired = st.unlock_active && (u_elapsed > {24'd0, cfg.unlock_timeout_seconds});
    b_elapsed = item.now_millis - st.blink_stamp;
    b_due     = b_elapsed > {16'd0, cfg.blink_half_period_ms};
  end

  // Place the key in its slot and match the full sequence
  always_comb begin
    slot      = (count >= CNT_W'(SEQ_LEN)) ? '0 : count;
    slot_plus = slot + CNT_W'(1);
    seq_full  = slot_plus == CNT_W'(SEQ_LEN);
    seq_match = 1'b1;
    for (int i = 0; i < SEQ_LEN; i++) begin
      keys_wr[i] = (slot == CNT_W'(i)) ? item.key_code : keys[i];
      if (keys_wr[i] != expected_key(cfg.unlock_sequence, i)) begin
        seq_match = 1'b0;
      end
    end
  end

  // Next state and result
  always_comb begin
    st_next    = st;
    keys_next  = keys;
    count_next = count;
    res        = '0;
    if (item.action == ACT_CHECK) begin
      res.service_required = req;
      res.service_warning  = warn;
      if (req) begin
        if (b_due) begin
          st_next.blink_stamp = item.now_millis;
          st_next.led_state   = !st.led_state;
        end
      end else begin
        if (q_due) begin
          st_next.quarter_stamp       = item.now_seconds;
          st_next.quarter_stamp_valid = 1'b1;
          st_next.quarters            = q_inc;
          if (q_inc > QUARTERS_PER_HOUR) begin
            if (st.hours_total != HOURS_MAX) begin
              st_next.hours_total = st.hours_total + 16'd1;
            end
            st_next.quarters = 3'd1;
          end
        end
        if (u_expired) begin
          st_next.unlock_active = 1'b0;
          count_next            = '0;
        end
        if (warn && b_due) begin
          st_next.blink_stamp = item.now_millis;
          st_next.led_state   = !st.led_state;
        end
      end
    end else begin
      if (!st.unlock_active) begin
        st_next.unlock_active = 1'b1;
        st_next.unlock_stamp  = item.now_seconds;
      end
      keys_next  = keys_wr;
      count_next = slot_plus;
      if (seq_full) begin
        count_next = '0;
        if (seq_match) begin
          st_next.hours_at_service = st.hours_total;
          st_next.quarters         = 3'd1;
          st_next.unlock_active    = 1'b0;
          res.reset_done           = 1'b1;
        end
      end
    end
    res.led_on          = st_next.led_state;
    res.operation_hours = st_next.hours_total;
    res.quarter_count   = st_next.quarters;
  end

endmodule

// ===== rtl/core/service_hour_meter_with_unlock_core.sv =====
// Path: an item transferred in sits in the input register, and its result is loaded
// into the result register when the item advances, which it does as soon as the result
// register is empty or its result is being taken.
// Throughput: one item per cycle; the single-pass update between the two registers
// sets that figure, and the input register holds one item while a result is stalled.
// Reset (rst, synchronous, active high): registers back to their defaults, counters
// and stamps cleared, LED off, both pipeline registers empty.
module service_hour_meter_with_unlock_core
  import shm_pkg::*;
#(
  parameter int SEQ_LEN = SEQ_LEN_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  shm_cfg_if.sink       cfg,
  shm_item_if.sink      item,
  shm_result_if.source  result
);

  localparam int CNT_W = $clog2(SEQ_LEN + 1);

  shm_cfg_t                cfg_regs;
  shm_core_t               st;
  shm_core_t               st_next;
  logic [SEQ_LEN-1:0][7:0] keys;
  logic [SEQ_LEN-1:0][7:0] keys_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    in_valid;
  shm_item_t               in_item;
  logic                    out_valid;
  shm_result_t             out_res;
  shm_result_t             res_next;
  logic                    advance;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.service_limit          <= SERVICE_LIMIT_RST;
      cfg_regs.warning_limit          <= WARNING_LIMIT_RST;
      cfg_regs.quarter_seconds        <= QUARTER_SECONDS_RST;
      cfg_regs.unlock_timeout_seconds <= UNLOCK_TIMEOUT_RST;
      cfg_regs.blink_half_period_ms   <= BLINK_HALF_RST;
      cfg_regs.unlock_sequence        <= UNLOCK_SEQ_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SERVICE_LIMIT:   cfg_regs.service_limit          <= cfg.data[15:0];
        REG_WARNING_LIMIT:   cfg_regs.warning_limit          <= cfg.data[15:0];
        REG_QUARTER_SECONDS: cfg_regs.quarter_seconds        <= cfg.data[15:0];
        REG_UNLOCK_TIMEOUT:  cfg_regs.unlock_timeout_seconds <= cfg.data[7:0];
        REG_BLINK_HALF:      cfg_regs.blink_half_period_ms   <= cfg.data[15:0];
        REG_UNLOCK_SEQUENCE: cfg_regs.unlock_sequence        <= cfg.data;
        default: ;
      endcase
    end
  end

  // Move the held item on whenever the result register is free or draining
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_item.action      <= item.action;
      in_item.key_code    <= item.key_code;
      in_item.now_seconds <= item.now_seconds;
      in_item.now_millis  <= item.now_millis;
    end
  end

  shm_step #(
    .SEQ_LEN (SEQ_LEN)
  ) u_step (
    .cfg        (cfg_regs),
    .st         (st),
    .keys       (keys),
    .count      (count),
    .item       (in_item),
    .st_next    (st_next),
    .keys_next  (keys_next),
    .count_next (count_next),
    .res        (res_next)
  );

  // Commit the meter state when an item passes
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      count <= '0;
    end else if (advance) begin
      st    <= st_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      keys <= keys_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.service_required = out_res.service_required;
  assign result.service_warning  = out_res.service_warning;
  assign result.reset_done       = out_res.reset_done;
  assign result.led_on           = out_res.led_on;
  assign result.operation_hours  = out_res.operation_hours;
  assign result.quarter_count    = out_res.quarter_count;

endmodule

// ===== rtl/core/shm_checker.sv =====
module shm_checker
  import shm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        service_required,
  input logic        service_warning,
  input logic        reset_done,
  input logic [2:0]  quarter_count
);

  // Hold a result until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  // Empty the result register on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Quarter count never passes a full hour
  a_quarter_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> quarter_count <= QUARTERS_PER_HOUR)
    else $error("quarter count out of range");

  // An unlock is a key result: restart quarters, no check flags
  a_unlock_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && reset_done |-> quarter_count == 3'd1 && !service_required
                                && !service_warning)
    else $error("unlock result inconsistent");

endmodule

bind service_hour_meter_with_unlock_core shm_checker u_shm_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .service_required (result.service_required),
  .service_warning  (result.service_warning),
  .reset_done       (result.reset_done),
  .quarter_count    (result.quarter_count)
);
